[rtl/core/hcr_pkg.sv]
`default_nettype none

package hcr_pkg;

  typedef enum logic [1:0] {
    MODE_SOLID  = 2'd0,
    MODE_DOTTED = 2'd1,
    MODE_HOLLOW = 2'd2,
    MODE_UNUSED = 2'd3
  } view_mode_t;

  typedef enum logic [1:0] {
    REG_VIEW_MODE   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_BOTTOM = 2'd2,
    REG_LEFT_EDGE   = 2'd3
  } reg_index_t;

  localparam logic CMD_PRIME = 1'b0;
  localparam logic CMD_PLOT  = 1'b1;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_DOT  = 1'b1;

endpackage

`default_nettype wire

[rtl/core/histogram_column_rasterizer.sv]
`default_nettype none

// Spectrum plot column rasterizer. Each input beat carries one pixel column and the screen row
// of its value; tuser is the command (0 prime the previous row, 1 plot the column). Plot beats
// give zero, one or two drawing primitives clipped to rows clip_top..clip_bottom, in solid,
// dotted or hollow step mode. Primitives go out of a four-entry result queue one beat per
// cycle while out_tready is high; each is registered into the queue when its input beat is
// taken. The input takes one beat per cycle while at most two queued primitives remain; a
// hollow rising step that gives both a line and a dot puts two primitives in the queue, so a
// stream of those fills the queue and holds the input back. Configuration writes are taken
// in any cycle and must be made while the block is idle.
module histogram_column_rasterizer
  import hcr_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int ROW_BITS   = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  // config write channel
  input  wire logic                                       cfg_valid,
  output logic                                            cfg_ready,
  input  wire logic [1:0]                                 cfg_index,
  input  wire logic [COORD_BITS-1:0]                      cfg_data,
  // input channel
  input  wire logic                                       in_tvalid,
  output logic                                            in_tready,
  // tdata: column, row_value (signed), zero pad
  input  wire logic [((COORD_BITS+ROW_BITS+7)/8)*8-1:0]   in_tdata,
  // tuser: cmd
  input  wire logic                                       in_tuser,
  // result channel
  output logic                                            out_tvalid,
  input  wire logic                                       out_tready,
  // tdata: out_column, row_from, row_to, zero pad
  output logic [((3*COORD_BITS+7)/8)*8-1:0]               out_tdata,
  // tuser: kind
  output logic                                            out_tuser,
  output logic                                            out_tlast
);

  localparam int IN_W  = ((COORD_BITS + ROW_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int CW    = (ROW_BITS > COORD_BITS) ? ROW_BITS : COORD_BITS + 1;
  localparam int DEPTH = 4;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] from;
    logic [COORD_BITS-1:0] to;
    logic                  last;
  } prim_t;

  view_mode_t            view_mode_r;
  logic [COORD_BITS-1:0] clip_top_r;
  logic [COORD_BITS-1:0] clip_bottom_r;
  logic [COORD_BITS-1:0] left_edge_r;
  logic [ROW_BITS-1:0]   prev_row_r;

  prim_t       queue_r [DEPTH];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;
  logic [2:0]  count_nxt;

  logic                  in_fire;
  logic                  out_fire;
  logic                  cfg_fire;
  logic                  cmd;
  logic [COORD_BITS-1:0] column;
  logic [ROW_BITS-1:0]   row_value;

  logic signed [CW-1:0]  ys;
  logic signed [CW-1:0]  lys;
  logic signed [CW-1:0]  top_s;
  logic signed [CW-1:0]  bot_s;

  prim_t      r0;
  prim_t      r1;
  logic [1:0] n_res;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign in_tready  = (count_r <= 3'(DEPTH - 2));
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != 3'd0);
  assign out_fire   = out_tvalid && out_tready;

  assign cmd       = in_tuser;
  assign column    = in_tdata[COORD_BITS-1:0];
  assign row_value = in_tdata[COORD_BITS+ROW_BITS-1:COORD_BITS];

  assign ys    = CW'($signed(row_value));
  assign lys   = CW'($signed(prev_row_r));
  assign top_s = CW'($signed({1'b0, clip_top_r}));
  assign bot_s = CW'($signed({1'b0, clip_bottom_r}));

  always_comb begin
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    prim_t                line_p;
    prim_t                dot_p;
    c      = ys;
    a      = lys;
    b      = ys;
    r0     = '0;
    r1     = '0;
    n_res  = 2'd0;
    line_p = '0;
    dot_p  = '0;
    if (cmd == CMD_PLOT) begin
      case (view_mode_r)
        MODE_SOLID: begin
          if (c < top_s) c = top_s;
          if (c > bot_s) c = bot_s;
          r0    = '{KIND_LINE, column, clip_bottom_r, c[COORD_BITS-1:0], 1'b1};
          n_res = 2'd1;
        end
        MODE_DOTTED: begin
          if (ys >= top_s && ys <= bot_s) begin
            r0    = '{KIND_DOT, column, ys[COORD_BITS-1:0], ys[COORD_BITS-1:0], 1'b1};
            n_res = 2'd1;
          end
        end
        MODE_HOLLOW: begin
          if (ys < lys) begin
            if (lys >= top_s && ys <= bot_s) begin
              a     = (lys > bot_s) ? bot_s : lys;
              b     = (ys < top_s) ? top_s : ys;
              r0    = '{KIND_LINE, column, a[COORD_BITS-1:0], b[COORD_BITS-1:0], 1'b1};
              n_res = 2'd1;
            end
          end else if (ys >= top_s && lys <= bot_s) begin
            a      = (lys < top_s) ? top_s : lys;
            b      = (ys > bot_s) ? bot_s : ys;
            line_p = '{KIND_LINE, column - COORD_BITS'(1), a[COORD_BITS-1:0],
                       b[COORD_BITS-1:0], 1'b0};
            dot_p  = '{KIND_DOT, column, b[COORD_BITS-1:0], b[COORD_BITS-1:0], 1'b1};
            if (column > left_edge_r) begin
              if (ys <= bot_s) begin
                r0    = line_p;
                r1    = dot_p;
                n_res = 2'd2;
              end else begin
                r0      = line_p;
                r0.last = 1'b1;
                n_res   = 2'd1;
              end
            end else if (ys <= bot_s) begin
              r0    = dot_p;
              n_res = 2'd1;
            end
          end
        end
        default: begin
          n_res = 2'd0;
        end
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_fire) count_nxt = count_nxt + {1'b0, n_res};
    if (out_fire) count_nxt = count_nxt - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_mode_r   <= MODE_HOLLOW;
      clip_top_r    <= '0;
      clip_bottom_r <= '0;
      left_edge_r   <= '0;
      prev_row_r    <= '0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      count_r       <= '0;
    end else begin
      if (cfg_fire) begin
        case (reg_index_t'(cfg_index))
          REG_VIEW_MODE:   view_mode_r   <= view_mode_t'(cfg_data[1:0]);
          REG_CLIP_TOP:    clip_top_r    <= cfg_data;
          REG_CLIP_BOTTOM: clip_bottom_r <= cfg_data;
          REG_LEFT_EDGE:   left_edge_r   <= cfg_data;
          default:         view_mode_r   <= view_mode_r;
        endcase
      end
      if (in_fire) begin
        prev_row_r <= row_value;
        wr_ptr_r   <= wr_ptr_r + n_res;
      end
      if (out_fire) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) queue_r[wr_ptr_r] <= r0;
    if (in_fire && n_res == 2'd2) queue_r[wr_ptr_r + 2'd1] <= r1;
  end

  assign out_tdata = OUT_W'({queue_r[rd_ptr_r].to, queue_r[rd_ptr_r].from,
                             queue_r[rd_ptr_r].col});
  assign out_tuser = queue_r[rd_ptr_r].kind;
  assign out_tlast = queue_r[rd_ptr_r].last;

  logic unused_pad;
  assign unused_pad = ^{1'b0, in_tdata[IN_W-1:COORD_BITS+ROW_BITS-1]};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'(DEPTH))
    else $error("result queue overfilled");

  a_prime_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_PRIME && !out_fire |=> count_r == $past(count_r))
    else $error("prime beat produced a primitive");

  a_solid_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_PLOT && view_mode_r == MODE_SOLID && !out_fire
      |=> count_r == $past(count_r) + 3'd1)
    else $error("solid bar did not give exactly one primitive");

  a_prev_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> prev_row_r == $past(row_value))
    else $error("previous row not loaded");

endmodule

`default_nettype wire

[verif/histogram_column_rasterizer_test.sv]
`timescale 1ns / 100ps

module histogram_column_rasterizer_test;
  import hcr_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int ROW_BITS = 16;
  localparam int IN_W = ((COORD_BITS + ROW_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 70;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic                       cmd;
    logic [COORD_BITS-1:0]      col;
    logic signed [ROW_BITS-1:0] row;
  } column_beat_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row_from;
    logic [COORD_BITS-1:0] row_to;
    logic                  last;
  } prim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_VIEW_MODE;
  logic [COORD_BITS-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;   // column, row_value, zero pad
  logic in_tuser = CMD_PRIME;       // cmd
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // out_column, row_from, row_to, zero pad
  logic out_tuser;                  // kind
  logic out_tlast;

  // shadow of the block's registers and state
  view_mode_t mode_q = MODE_HOLLOW;
  logic [COORD_BITS-1:0] clip_top_q = '0;
  logic [COORD_BITS-1:0] clip_bottom_q = '0;
  logic [COORD_BITS-1:0] left_edge_q = '0;
  logic signed [ROW_BITS-1:0] prev_row = '0;

  column_beat_t pending_columns[$];
  prim_t expected_prims[$];
  int columns_queued = 0;
  int columns_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int max_gap = 3;
  int max_stall = 3;
  int gap_left = 0;
  int burst_left = 0;
  int run_left = 0;
  int stall_left = 0;

  histogram_column_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .ROW_BITS  (ROW_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic prim_t make_prim(logic kind, int col, int row_from, int row_to);
    prim_t p;
    p.kind = kind;
    p.col = col[COORD_BITS-1:0];
    p.row_from = row_from[COORD_BITS-1:0];
    p.row_to = row_to[COORD_BITS-1:0];
    p.last = 1'b0;
    return p;
  endfunction

  function automatic void rasterize_column(logic cmd, logic [COORD_BITS-1:0] col,
                                           logic signed [ROW_BITS-1:0] row);
    int y, ly, top, bot, lo, hi;
    prim_t prims[$];
    y = row;
    ly = prev_row;
    top = clip_top_q;
    bot = clip_bottom_q;
    prev_row = row;
    if (cmd == CMD_PLOT) begin
      case (mode_q)
        MODE_SOLID: begin
          lo = (y < top) ? top : y;
          lo = (lo > bot) ? bot : lo;
          prims.push_back(make_prim(KIND_LINE, col, bot, lo));
        end
        MODE_DOTTED: begin
          if (y >= top && y <= bot) prims.push_back(make_prim(KIND_DOT, col, y, y));
        end
        MODE_HOLLOW: begin
          if (y < ly) begin
            if (ly >= top && y <= bot)
              prims.push_back(make_prim(KIND_LINE, col, (ly > bot) ? bot : ly,
                                        (y < top) ? top : y));
          end else if (y >= top && ly <= bot) begin
            lo = (ly < top) ? top : ly;
            hi = (y > bot) ? bot : y;
            if (col > left_edge_q) prims.push_back(make_prim(KIND_LINE, col - 1, lo, hi));
            if (y <= bot) prims.push_back(make_prim(KIND_DOT, col, hi, hi));
          end
        end
        default: ;
      endcase
    end
    if (prims.size() > 0) prims[prims.size()-1].last = 1'b1;
    foreach (prims[i]) expected_prims.push_back(prims[i]);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // input side: bursts with random gaps
  always @(posedge clk) begin
    column_beat_t next_col;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_columns.size() > 0) begin
        next_col = pending_columns.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {{(IN_W-COORD_BITS-ROW_BITS){1'b0}}, next_col.row, next_col.col};
        in_tuser <= next_col.cmd;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side: ready runs and stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_tready <= 1'b1;
    end else begin
      run_left = $urandom_range(1, 12);
      stall_left = (max_stall == 0) ? 0 : $urandom_range(0, max_stall);
      out_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    prim_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        rasterize_column(in_tuser, in_tdata[COORD_BITS-1:0],
                         in_tdata[COORD_BITS+ROW_BITS-1:COORD_BITS]);
        columns_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_prims.size() == 0) begin
          $error("primitive with nothing expected: column %0d",
                 out_tdata[COORD_BITS-1:0]);
          mismatch_count++;
        end else begin
          want = expected_prims.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("out_column", want.col, out_tdata[COORD_BITS-1:0]);
          check_field("row_from", want.row_from, out_tdata[2*COORD_BITS-1:COORD_BITS]);
          check_field("row_to", want.row_to, out_tdata[3*COORD_BITS-1:2*COORD_BITS]);
          check_field("last", want.last, out_tlast);
        end
      end
    end
  end

  task automatic queue_item(logic cmd, logic [COORD_BITS-1:0] col,
                            logic signed [ROW_BITS-1:0] row);
    column_beat_t b;
    b.cmd = cmd;
    b.col = col;
    b.row = row;
    pending_columns.push_back(b);
    columns_queued++;
  endtask

  task automatic wait_idle();
    while (columns_taken != columns_queued || expected_prims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [COORD_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_VIEW_MODE:   mode_q = view_mode_t'(value[1:0]);
      REG_CLIP_TOP:    clip_top_q = value;
      REG_CLIP_BOTTOM: clip_bottom_q = value;
      REG_LEFT_EDGE:   left_edge_q = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic program_plot(view_mode_t mode, int top, int bot, int left);
    wait_idle();
    write_reg(REG_VIEW_MODE, COORD_BITS'(mode));
    write_reg(REG_CLIP_TOP, COORD_BITS'(top));
    write_reg(REG_CLIP_BOTTOM, COORD_BITS'(bot));
    write_reg(REG_LEFT_EDGE, COORD_BITS'(left));
  endtask

  // mostly near the window, sometimes anywhere or at the extremes
  function automatic logic signed [ROW_BITS-1:0] pick_row(int top, int bot);
    int lo, hi;
    lo = ((top < bot) ? top : bot) - 16;
    hi = ((top < bot) ? bot : top) + 16;
    case ($urandom_range(0, 9))
      0: return ROW_BITS'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return ROW_BITS'(lo + $urandom_range(0, hi - lo));
    endcase
  endfunction

  initial begin
    int p, j, k, len, col, top, bot, left;
    view_mode_t mode;
    logic signed [ROW_BITS-1:0] row;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: hollow, one-row window, left edge 0
    queue_item(CMD_PLOT, 0, 0);
    queue_item(CMD_PLOT, 1, -1);

    program_plot(MODE_HOLLOW, 100, 400, 10);
    queue_item(CMD_PRIME, 0, 300);
    queue_item(CMD_PLOT, 50, 200);
    queue_item(CMD_PLOT, 51, 350);
    queue_item(CMD_PLOT, 10, 380);
    queue_item(CMD_PLOT, 11, 380);
    queue_item(CMD_PRIME, 0, 32767);
    queue_item(CMD_PLOT, 13, -32768);
    queue_item(CMD_PLOT, 14, 32767);
    queue_item(CMD_PLOT, 4095, 500);

    program_plot(MODE_SOLID, 100, 400, 10);
    queue_item(CMD_PLOT, 20, 250);
    queue_item(CMD_PLOT, 21, -32768);
    queue_item(CMD_PLOT, 4095, 32767);

    program_plot(MODE_DOTTED, 100, 400, 10);
    queue_item(CMD_PLOT, 30, 100);
    queue_item(CMD_PLOT, 31, 401);
    queue_item(CMD_PLOT, 32, 99);

    // unused mode still moves the previous row
    program_plot(MODE_UNUSED, 100, 400, 10);
    queue_item(CMD_PLOT, 40, 200);

    // inverted window
    program_plot(MODE_HOLLOW, 300, 200, 5);
    queue_item(CMD_PLOT, 41, 350);
    queue_item(CMD_PLOT, 42, 100);
    program_plot(MODE_SOLID, 300, 200, 5);
    queue_item(CMD_PLOT, 43, 250);

    program_plot(MODE_HOLLOW, 0, 4095, 4095);
    queue_item(CMD_PRIME, 4095, 4095);
    queue_item(CMD_PLOT, 4095, 0);
    queue_item(CMD_PLOT, 4095, 4095);

    for (p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: begin top = 0; bot = 4095; end
        1: begin top = $urandom_range(0, 4095); bot = top; end
        2: begin bot = $urandom_range(0, 4000); top = bot + $urandom_range(1, 4095 - bot); end
        3: begin top = 4095 * $urandom_range(0, 1); bot = top; end
        default: begin top = $urandom_range(0, 3000); bot = top + $urandom_range(1, 1095); end
      endcase
      case ($urandom_range(0, 3))
        0: left = 0;
        1: left = 4095;
        default: left = $urandom_range(0, 4095);
      endcase
      if ($urandom_range(0, 7) == 0) mode = MODE_UNUSED;
      else mode = view_mode_t'($urandom_range(MODE_SOLID, MODE_HOLLOW));
      max_gap = (p % 4 == 0) ? 0 : $urandom_range(1, 6);
      max_stall = (p % 3 == 1) ? 0 : $urandom_range(1, 6);
      program_plot(mode, top, bot, left);

      k = 0;
      while (k < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_item(1'($urandom_range(0, 1)), COORD_BITS'($urandom), ROW_BITS'($urandom));
          k++;
        end else begin
          // primed sweep across adjacent columns
          len = $urandom_range(3, 20);
          col = $urandom_range(0, 1) ? left + $urandom_range(0, 3) - 2 : $urandom_range(0, 4095);
          row = pick_row(top, bot);
          queue_item(CMD_PRIME, COORD_BITS'(col - 1), row);
          for (j = 0; j < len; j++) begin
            if ($urandom_range(0, 5) != 0) row = pick_row(top, bot);
            queue_item(CMD_PLOT, COORD_BITS'(col + j), row);
          end
          k += len + 1;
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/hcr_pkg.sv
rtl/core/histogram_column_rasterizer.sv
verif/histogram_column_rasterizer_test.sv
